// ----- rtl/core/wshc_pkg.sv -----
// Shared constants, register codes and stage payload types of the size-hint constrain unit.
package wshc_pkg;

    // Design constants.
    localparam int DIM_BITS         = 16;
    localparam int ASPECT_FRAC_BITS = 16;
    localparam int FLOOR_WIDTH      = 32;
    localparam int FLOOR_HEIGHT     = 32;

    // Field and datapath widths.
    localparam int HALF_W     = 16;
    localparam int FL_W       = HALF_W - 1;
    localparam int OTH_W      = HALF_W + 2;
    localparam int LIM_W      = 32;
    localparam int PROD_W     = LIM_W + 1 + OTH_W;
    localparam int CLAMP_BITS = ((DIM_BITS > HALF_W) ? DIM_BITS : HALF_W) + 1;
    localparam int MAG_W      = CLAMP_BITS + 1;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = (MAG_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W      = DIV_STAGES * DIV_STEP;
    localparam int FIN_W      = MAG_W + 2;

    // Largest dimension before the output is cut to its field width.
    localparam logic [FIN_W-1:0] DIM_TOP = FIN_W'((64'd1 << DIM_BITS) - 64'd1);

    // Configuration port.
    localparam int CFG_W = 64;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_BASE_SIZE     = 3'd0;
    localparam logic [IDX_W-1:0] REG_MIN_SIZE      = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAX_SIZE      = 3'd2;
    localparam logic [IDX_W-1:0] REG_SIZE_STEP     = 3'd3;
    localparam logic [IDX_W-1:0] REG_ASPECT_LIMITS = 3'd4;
    localparam logic [IDX_W-1:0] REG_HINT_ENABLE   = 3'd5;
    localparam logic [IDX_W-1:0] REG_LAST_SIZE     = 3'd6;

    typedef struct packed {
        logic [31:0] base_size;
        logic [31:0] min_size;
        logic [31:0] max_size;
        logic [31:0] size_step;
        logic [63:0] aspect_limits;
        logic [1:0]  hint_enable;
        logic [31:0] last_size;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        base_size:     '0,
        min_size:      '0,
        max_size:      '0,
        size_step:     '0,
        aspect_limits: '0,
        hint_enable:   2'b01,
        last_size:     '0
    };

    // Request as it enters the pipeline.
    typedef struct packed {
        logic                     force_hints;
        logic                     is_floated;
        logic                     is_pseudotiled;
        logic signed [HALF_W-1:0] req_height;
        logic signed [HALF_W-1:0] req_width;
    } req_t;

    // Floored size, hint decision and base-adjusted size.
    typedef struct packed {
        logic                    hints_on;
        logic                    base_is_min;
        logic [FL_W-1:0]         fl_w;
        logic [FL_W-1:0]         fl_h;
        logic signed [OTH_W-1:0] w1;
        logic signed [OTH_W-1:0] h1;
    } base_t;

    // Base stage plus the two aspect products.
    typedef struct packed {
        base_t                    b;
        logic signed [PROD_W-1:0] p_max;
        logic signed [PROD_W-1:0] p_min;
    } prod_t;

    // Sign and clamped magnitude of each dimension ahead of the increment snap.
    typedef struct packed {
        logic             hints_on;
        logic [FL_W-1:0]  fl_w;
        logic [FL_W-1:0]  fl_h;
        logic             neg_w;
        logic             neg_h;
        logic [MAG_W-1:0] mag_w;
        logic [MAG_W-1:0] mag_h;
    } mag_t;

    // Magnitudes with their partial remainders by the increments.
    typedef struct packed {
        mag_t              m;
        logic [HALF_W-1:0] rem_w;
        logic [HALF_W-1:0] rem_h;
    } quo_t;

    // Result item.
    typedef struct packed {
        logic              size_changed;
        logic [HALF_W-1:0] out_height;
        logic [HALF_W-1:0] out_width;
    } res_t;

endpackage

// ----- rtl/core/window_size_hint_constrain_unit.sv -----
// Throughput: one transaction per cycle; every stage holds its item under back-pressure.
// Depth is set by the remainder pipeline: three dividend bits per stage over the clamped
// magnitude, two lanes side by side, after two front, two aspect and ahead of two back stages.
// Reset: synchronous active-low aresetn empties all stages and loads the register defaults
// (all zero, hint_enable 1); there is no clearing pass.
module window_size_hint_constrain_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write port.
    input  logic                        cfg_we,
    input  logic [wshc_pkg::IDX_W-1:0]  cfg_addr,
    input  logic [wshc_pkg::CFG_W-1:0]  cfg_wdata,
    // Request stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,  // [15:0] req_width, [31:16] req_height
    input  logic [2:0]                  s_tuser,  // [0] force_hints, [1] is_floated,
                                                  // [2] is_pseudotiled
    // Result stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,  // [15:0] out_width, [31:16] out_height
    output logic [0:0]                  m_tuser   // [0] size_changed
);
    import wshc_pkg::*;

    cfg_t  cfg_reg;
    req_t  req;
    prod_t prep_data;
    mag_t  asp_data;
    quo_t  div_data;
    res_t  res;

    logic prep_valid;
    logic prep_ready;
    logic asp_valid;
    logic asp_ready;
    logic div_valid;
    logic div_ready;

    // Register file: one write per cycle, unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_BASE_SIZE:     cfg_reg.base_size     <= cfg_wdata[31:0];
                REG_MIN_SIZE:      cfg_reg.min_size      <= cfg_wdata[31:0];
                REG_MAX_SIZE:      cfg_reg.max_size      <= cfg_wdata[31:0];
                REG_SIZE_STEP:     cfg_reg.size_step     <= cfg_wdata[31:0];
                REG_ASPECT_LIMITS: cfg_reg.aspect_limits <= cfg_wdata[63:0];
                REG_HINT_ENABLE:   cfg_reg.hint_enable   <= cfg_wdata[1:0];
                REG_LAST_SIZE:     cfg_reg.last_size     <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Unpack the request transaction.
    assign req.req_width      = s_tdata[15:0];
    assign req.req_height     = s_tdata[31:16];
    assign req.force_hints    = s_tuser[0];
    assign req.is_floated     = s_tuser[1];
    assign req.is_pseudotiled = s_tuser[2];

    wshc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (req),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    wshc_aspect u_aspect (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (asp_valid),
        .out_ready (asp_ready),
        .out_data  (asp_data)
    );

    wshc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (asp_valid),
        .in_ready  (asp_ready),
        .in_data   (asp_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    wshc_final u_final (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // Pack the result transaction.
    assign m_tdata = {res.out_height, res.out_width};
    assign m_tuser = res.size_changed;

`ifndef SYNTHESIS
    // With the output register empty every stage can move, so a request is always taken.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request refused with empty output register");
`endif

endmodule

// ----- rtl/core/wshc_prep.sv -----
// Front stages: floor, hint decision, base removal and the two aspect products.
module wshc_prep (
    input  logic             aclk,
    input  logic             aresetn,
    input  wshc_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  wshc_pkg::req_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output wshc_pkg::prod_t  out_data
);
    import wshc_pkg::*;

    logic  a_valid_reg;
    logic  b_valid_reg;
    logic  a_en;
    logic  b_en;
    base_t a_data_reg;
    base_t a_data_next;
    prod_t b_data_reg;
    prod_t b_data_next;

    logic [HALF_W-1:0] base_w;
    logic [HALF_W-1:0] base_h;
    logic [LIM_W-1:0]  aspect_hw_lo;
    logic [LIM_W-1:0]  aspect_wh_hi;

    assign base_w       = cfg.base_size[HALF_W-1:0];
    assign base_h       = cfg.base_size[2*HALF_W-1:HALF_W];
    assign aspect_hw_lo = cfg.aspect_limits[LIM_W-1:0];
    assign aspect_wh_hi = cfg.aspect_limits[2*LIM_W-1:LIM_W];

    // A stage moves when it is empty or the one after it moves.
    assign b_en     = !b_valid_reg || out_ready;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    // Stage A: raise to the floor, pick the enable bit, take the base off early if needed.
    always_comb begin
        if (in_data.force_hints || in_data.is_floated || in_data.is_pseudotiled) begin
            a_data_next.hints_on = cfg.hint_enable[0];
        end else begin
            a_data_next.hints_on = cfg.hint_enable[1];
        end
        if (in_data.req_width < FLOOR_WIDTH) begin
            a_data_next.fl_w = FL_W'(FLOOR_WIDTH);
        end else begin
            a_data_next.fl_w = in_data.req_width[FL_W-1:0];
        end
        if (in_data.req_height < FLOOR_HEIGHT) begin
            a_data_next.fl_h = FL_W'(FLOOR_HEIGHT);
        end else begin
            a_data_next.fl_h = in_data.req_height[FL_W-1:0];
        end
        a_data_next.base_is_min = (cfg.base_size == cfg.min_size);
        if (a_data_next.base_is_min) begin
            a_data_next.w1 = OTH_W'(a_data_next.fl_w);
            a_data_next.h1 = OTH_W'(a_data_next.fl_h);
        end else begin
            a_data_next.w1 = OTH_W'(a_data_next.fl_w) - OTH_W'(base_w);
            a_data_next.h1 = OTH_W'(a_data_next.fl_h) - OTH_W'(base_h);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_data_reg <= a_data_next;
        end
    end

    // Stage B: cross products used both for the aspect tests and for rounding.
    always_comb begin
        b_data_next.b     = a_data_reg;
        b_data_next.p_max = $signed({1'b0, aspect_wh_hi}) * $signed(a_data_reg.h1);
        b_data_next.p_min = $signed({1'b0, aspect_hw_lo}) * $signed(a_data_reg.w1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_en) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

// ----- rtl/core/wshc_aspect.sv -----
// Aspect stages: limit tests, rounded replacement, late base removal and range clamp.
module wshc_aspect (
    input  logic             aclk,
    input  logic             aresetn,
    input  wshc_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  wshc_pkg::prod_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output wshc_pkg::mag_t   out_data
);
    import wshc_pkg::*;

    typedef struct packed {
        base_t                    b;
        logic                     below_w;
        logic                     below_h;
        logic signed [PROD_W-1:0] q_w;
        logic signed [PROD_W-1:0] q_h;
    } asp_t;

    localparam logic [PROD_W-1:0] RND_HALF  = PROD_W'(1) << (ASPECT_FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] RND_MASK  = (PROD_W'(1) << ASPECT_FRAC_BITS) - PROD_W'(1);
    localparam logic [PROD_W-1:0] CLAMP_VAL = PROD_W'(1) << CLAMP_BITS;

    logic c_valid_reg;
    logic d_valid_reg;
    logic c_en;
    logic d_en;
    asp_t c_data_reg;
    asp_t c_data_next;
    mag_t d_data_reg;
    mag_t d_data_next;
    logic aspect_on;

    // True when lim / 2^F lies below num / den; den of zero means +inf for positive num.
    function automatic logic limit_below(input logic signed [PROD_W-1:0] lhs,
                                         input logic signed [OTH_W-1:0]  num,
                                         input logic signed [OTH_W-1:0]  den);
        logic signed [PROD_W-1:0] rhs;
        logic                     res;
        rhs = PROD_W'(num) <<< ASPECT_FRAC_BITS;
        if (den > 0) begin
            res = (lhs < rhs);
        end else if (den < 0) begin
            res = (lhs > rhs);
        end else begin
            res = (num > 0);
        end
        return res;
    endfunction

    // Add one half and drop the fraction, truncating toward zero.
    function automatic logic signed [PROD_W-1:0] aspect_round(
        input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] v;
        v = p + $signed(RND_HALF);
        if (v < 0) begin
            v = v + $signed(RND_MASK);
        end
        return v >>> ASPECT_FRAC_BITS;
    endfunction

    // Sign and magnitude, with far-off values held at a bound that gives the same result.
    function automatic logic [MAG_W:0] to_mag(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] a;
        logic [MAG_W:0]           res;
        if (v >= $signed(CLAMP_VAL)) begin
            res = {1'b0, CLAMP_VAL[MAG_W-1:0]};
        end else if (v <= -$signed(CLAMP_VAL)) begin
            res = {1'b1, CLAMP_VAL[MAG_W-1:0]};
        end else begin
            a   = (v < 0) ? -v : v;
            res = {(v < 0), a[MAG_W-1:0]};
        end
        return res;
    endfunction

    assign aspect_on = (cfg.aspect_limits[LIM_W-1:0] != '0)
                    && (cfg.aspect_limits[2*LIM_W-1:LIM_W] != '0);

    assign d_en     = !d_valid_reg || out_ready;
    assign c_en     = !c_valid_reg || d_en;
    assign in_ready = c_en;

    // Stage C: both limit tests and both rounded candidates side by side.
    always_comb begin
        c_data_next.b       = in_data.b;
        c_data_next.below_w = limit_below(in_data.p_max, in_data.b.w1, in_data.b.h1);
        c_data_next.below_h = limit_below(in_data.p_min, in_data.b.h1, in_data.b.w1);
        c_data_next.q_w     = aspect_round(in_data.p_max);
        c_data_next.q_h     = aspect_round(in_data.p_min);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_en) begin
            c_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_en) begin
            c_data_reg <= c_data_next;
        end
    end

    // Stage D: apply the aspect choice, take the base off late if needed, clamp.
    always_comb begin
        logic signed [PROD_W-1:0] w2;
        logic signed [PROD_W-1:0] h2;
        logic [MAG_W:0]           mw;
        logic [MAG_W:0]           mh;
        w2 = PROD_W'(c_data_reg.b.w1);
        h2 = PROD_W'(c_data_reg.b.h1);
        if (aspect_on) begin
            if (c_data_reg.below_w) begin
                w2 = c_data_reg.q_w;
            end else if (c_data_reg.below_h) begin
                h2 = c_data_reg.q_h;
            end
        end
        if (c_data_reg.b.base_is_min) begin
            w2 = w2 - $signed({1'b0, cfg.base_size[HALF_W-1:0]});
            h2 = h2 - $signed({1'b0, cfg.base_size[2*HALF_W-1:HALF_W]});
        end
        mw = to_mag(w2);
        mh = to_mag(h2);
        d_data_next.hints_on = c_data_reg.b.hints_on;
        d_data_next.fl_w     = c_data_reg.b.fl_w;
        d_data_next.fl_h     = c_data_reg.b.fl_h;
        d_data_next.neg_w    = mw[MAG_W];
        d_data_next.neg_h    = mh[MAG_W];
        d_data_next.mag_w    = mw[MAG_W-1:0];
        d_data_next.mag_h    = mh[MAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (d_en) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_en) begin
            d_data_reg <= d_data_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

endmodule

// ----- rtl/core/wshc_div.sv -----
// Pipelined restoring remainder of both magnitudes by their resize increments.
module wshc_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  wshc_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  wshc_pkg::mag_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output wshc_pkg::quo_t  out_data
);
    import wshc_pkg::*;

    quo_t data_reg  [DIV_STAGES];
    logic valid_reg [DIV_STAGES];
    logic stage_en  [DIV_STAGES];

    logic [HALF_W-1:0] inc_w;
    logic [HALF_W-1:0] inc_h;

    assign inc_w = cfg.size_step[HALF_W-1:0];
    assign inc_h = cfg.size_step[2*HALF_W-1:HALF_W];

    // Bring in the next dividend bits, most significant first, one subtract each.
    function automatic logic [HALF_W-1:0] rem_step(input logic [HALF_W-1:0]   r_in,
                                                   input logic [DIV_STEP-1:0] bits,
                                                   input logic [HALF_W-1:0]   d);
        logic [HALF_W-1:0] r;
        logic [HALF_W:0]   sh;
        r = r_in;
        for (int k = DIV_STEP - 1; k >= 0; k--) begin
            sh = {r, bits[k]};
            if (sh >= {1'b0, d}) begin
                sh = sh - {1'b0, d};
            end
            r = sh[HALF_W-1:0];
        end
        return r;
    endfunction

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        quo_t             stage_in;
        logic             stage_in_valid;
        logic             down_ready;
        quo_t             data_next;
        logic [DIV_W-1:0] dvd_w;
        logic [DIV_W-1:0] dvd_h;

        if (g == 0) begin : g_first
            assign stage_in.m     = in_data;
            assign stage_in.rem_w = '0;
            assign stage_in.rem_h = '0;
            assign stage_in_valid = in_valid;
        end else begin : g_chain
            assign stage_in       = data_reg[g-1];
            assign stage_in_valid = valid_reg[g-1];
        end

        if (g == DIV_STAGES - 1) begin : g_last
            assign down_ready = out_ready;
        end else begin : g_mid
            assign down_ready = stage_en[g+1];
        end

        assign stage_en[g] = !valid_reg[g] || down_ready;

        // Leading zeros pad the magnitude to a whole number of stages.
        assign dvd_w = DIV_W'(stage_in.m.mag_w);
        assign dvd_h = DIV_W'(stage_in.m.mag_h);

        always_comb begin
            data_next       = stage_in;
            data_next.rem_w = rem_step(stage_in.rem_w,
                                       dvd_w[DIV_W-1-DIV_STEP*g -: DIV_STEP], inc_w);
            data_next.rem_h = rem_step(stage_in.rem_h,
                                       dvd_h[DIV_W-1-DIV_STEP*g -: DIV_STEP], inc_h);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (stage_en[g]) begin
                valid_reg[g] <= stage_in_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[g]) begin
                data_reg[g] <= data_next;
            end
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_data  = data_reg[DIV_STAGES-1];

`ifndef SYNTHESIS
    // A stalled item in the last divider stage keeps its partial results.
    a_div_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[DIV_STAGES-1] && !out_ready
        |=> valid_reg[DIV_STAGES-1] && (data_reg[DIV_STAGES-1] == $past(data_reg[DIV_STAGES-1])))
        else $error("divider output stage changed while stalled");
`endif

endmodule

// ----- rtl/core/wshc_final.sv -----
// Back stages: snap, base restore, min and max limits, saturation and change flag.
module wshc_final (
    input  logic            aclk,
    input  logic            aresetn,
    input  wshc_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  wshc_pkg::quo_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output wshc_pkg::res_t  out_data
);
    import wshc_pkg::*;

    typedef struct packed {
        logic                    hints_on;
        logic [FL_W-1:0]         fl_w;
        logic [FL_W-1:0]         fl_h;
        logic signed [FIN_W-1:0] v_w;
        logic signed [FIN_W-1:0] v_h;
    } snap_t;

    typedef struct packed {
        logic hints_on;
        res_t res;
    } out_t;

    logic  e_valid_reg;
    logic  f_valid_reg;
    logic  e_en;
    logic  f_en;
    snap_t e_data_reg;
    snap_t e_data_next;
    out_t  f_data_reg;
    out_t  f_data_next;

    logic [HALF_W-1:0] ow;
    logic [HALF_W-1:0] oh;

    // Drop the remainder and put sign and base back.
    function automatic logic signed [FIN_W-1:0] restore(input logic [MAG_W-1:0]  mag,
                                                        input logic [HALF_W-1:0] rem,
                                                        input logic [HALF_W-1:0] inc,
                                                        input logic              neg,
                                                        input logic [HALF_W-1:0] base);
        logic [MAG_W-1:0]        t;
        logic signed [FIN_W-1:0] sv;
        t = (inc == '0) ? mag : (mag - MAG_W'(rem));
        sv = $signed({2'b00, t});
        if (neg) begin
            sv = -sv;
        end
        return sv + $signed(FIN_W'(base));
    endfunction

    // Limits when hints apply, then saturation to the dimension range.
    function automatic logic [HALF_W-1:0] fit_dim(input logic                    hints_on,
                                                  input logic [FL_W-1:0]         fl,
                                                  input logic signed [FIN_W-1:0] v,
                                                  input logic [HALF_W-1:0]       mn,
                                                  input logic [HALF_W-1:0]       mx);
        logic signed [FIN_W-1:0] x;
        x = hints_on ? v : $signed(FIN_W'(fl));
        if (hints_on) begin
            if (x < $signed(FIN_W'(mn))) begin
                x = $signed(FIN_W'(mn));
            end
            if ((mx != '0) && (x > $signed(FIN_W'(mx)))) begin
                x = $signed(FIN_W'(mx));
            end
        end
        if (x < 0) begin
            x = '0;
        end else if (x > $signed(DIM_TOP)) begin
            x = $signed(DIM_TOP);
        end
        return x[HALF_W-1:0];
    endfunction

    assign f_en     = !f_valid_reg || out_ready;
    assign e_en     = !e_valid_reg || f_en;
    assign in_ready = e_en;

    // Stage E: snapped signed values with the base added back.
    always_comb begin
        e_data_next.hints_on = in_data.m.hints_on;
        e_data_next.fl_w     = in_data.m.fl_w;
        e_data_next.fl_h     = in_data.m.fl_h;
        e_data_next.v_w      = restore(in_data.m.mag_w, in_data.rem_w,
                                       cfg.size_step[HALF_W-1:0], in_data.m.neg_w,
                                       cfg.base_size[HALF_W-1:0]);
        e_data_next.v_h      = restore(in_data.m.mag_h, in_data.rem_h,
                                       cfg.size_step[2*HALF_W-1:HALF_W], in_data.m.neg_h,
                                       cfg.base_size[2*HALF_W-1:HALF_W]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (e_en) begin
            e_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_en) begin
            e_data_reg <= e_data_next;
        end
    end

    // Stage F, the output register: limits, saturation and the change flag.
    always_comb begin
        ow = fit_dim(e_data_reg.hints_on, e_data_reg.fl_w, e_data_reg.v_w,
                     cfg.min_size[HALF_W-1:0], cfg.max_size[HALF_W-1:0]);
        oh = fit_dim(e_data_reg.hints_on, e_data_reg.fl_h, e_data_reg.v_h,
                     cfg.min_size[2*HALF_W-1:HALF_W], cfg.max_size[2*HALF_W-1:HALF_W]);
        f_data_next.hints_on         = e_data_reg.hints_on;
        f_data_next.res.out_width    = ow;
        f_data_next.res.out_height   = oh;
        f_data_next.res.size_changed = (ow != cfg.last_size[HALF_W-1:0])
                                    || (oh != cfg.last_size[2*HALF_W-1:HALF_W]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (f_en) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_en) begin
            f_data_reg <= f_data_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_data  = f_data_reg.res;

`ifndef SYNTHESIS
    // Without hints the result never drops below the floor.
    a_floor_width: assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid_reg && !f_data_reg.hints_on
        |-> f_data_reg.res.out_width >= HALF_W'(FLOOR_WIDTH))
        else $error("unhinted width below floor");
`endif

`ifndef SYNTHESIS
    a_floor_height: assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid_reg && !f_data_reg.hints_on
        |-> f_data_reg.res.out_height >= HALF_W'(FLOOR_HEIGHT))
        else $error("unhinted height below floor");
`endif

endmodule
